/* hdl/hid_keyboard_report_diff_defines.svh */
// ----------------------------------------------------------------------------
// hid_keyboard_report_diff_defines
// Assertion macros for the keyboard report differ.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_DIFF_DEFINES_SVH
`define HID_KEYBOARD_REPORT_DIFF_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HKRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hid_keyboard_report_diff: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HKRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hid_keyboard_report_diff: next-cycle check failed");

`endif

/* hdl/hkrd_pkg.sv */
// ----------------------------------------------------------------------------
// hkrd_pkg
// Shared types and constants of the keyboard report differ.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrd_pkg;

  localparam int KEY_W     = 8;  // keycode width
  localparam int MAX_SLOTS = 6;  // slots in a boot keyboard report

  typedef logic [KEY_W-1:0] key_t;

  // One key event as it leaves the block.
  typedef struct packed {
    key_t key;
    logic is_press;
    logic last;
  } evt_t;

endpackage

`default_nettype wire

/* hdl/hkrd_lane.sv */
// ----------------------------------------------------------------------------
// hkrd_lane
// One compare lane: flags a nonzero code that is absent from a report.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrd_lane #(
  parameter int SLOTS = 6
) (
  input  wire hkrd_pkg::key_t             code,
  input  wire hkrd_pkg::key_t [SLOTS-1:0] report,
  output logic                            hit
);

  logic [SLOTS-1:0] match;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = (report[i] == code);
    end
  end

  assign hit = (code != '0) && (match == '0);

endmodule

`default_nettype wire

/* hdl/hkrd_merge.sv */
// ----------------------------------------------------------------------------
// hkrd_merge
// Holds lane results of one report and sends them out one event a cycle, stalled while out_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrd_merge #(
  parameter int LANES = 12
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             ld,
  input  wire [LANES-1:0]                 ld_mask,
  input  wire hkrd_pkg::key_t [LANES-1:0] ld_codes,
  output logic                            ld_ready,
  output logic                            out_valid,
  input  wire                             out_ready,
  output hkrd_pkg::evt_t                  out_evt
);

  localparam int PRESS_LANES = LANES / 2;

  logic [LANES-1:0]           pend_r, pend_nxt;
  hkrd_pkg::key_t [LANES-1:0] code_r;
  logic                       out_valid_r, out_valid_nxt;
  hkrd_pkg::evt_t             evt_r, evt_nxt;

  logic [LANES-1:0] pick;
  logic [LANES-1:0] rem;
  logic             out_free;
  logic             pop;
  hkrd_pkg::key_t   pick_key;

  // lowest pending lane goes first: presses, then releases, slot order
  assign pick     = pend_r & (~pend_r + {{(LANES-1){1'b0}}, 1'b1});
  assign out_free = !out_valid_r || out_ready;
  assign pop      = (pend_r != '0) && out_free;
  assign rem      = pop ? (pend_r & ~pick) : pend_r;
  assign ld_ready = (rem == '0);

  always_comb begin
    pick_key = '0;
    for (int i = 0; i < LANES; i++) begin
      pick_key = pick_key | (code_r[i] & {hkrd_pkg::KEY_W{pick[i]}});
    end
  end

  always_comb begin
    pend_nxt      = ld ? ld_mask : rem;
    out_valid_nxt = out_valid_r;
    evt_nxt       = evt_r;
    if (pop) begin
      out_valid_nxt    = 1'b1;
      evt_nxt.key      = pick_key;
      evt_nxt.is_press = |pick[PRESS_LANES-1:0];
      evt_nxt.last     = (rem == '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    evt_r <= evt_nxt;
    if (ld) begin
      code_r <= ld_codes;
    end
  end

  assign out_valid = out_valid_r;
  assign out_evt   = evt_r;

endmodule

`default_nettype wire

/* hdl/hid_keyboard_report_diff.sv */
// ----------------------------------------------------------------------------
// hid_keyboard_report_diff
// Key press/release events from successive boot keyboard reports.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                             | transaction
//  ---------+-----+-------------------------------------+-------------------------
//  in_      | in  | tdata: 6 keycodes, slot 0 lowest     | tvalid & tready
//  out_     | out | tdata: key, tuser: press, tlast: last| tvalid & tready
//
//  A report's events leave one per cycle while out_tready is high, at most
//  2*SLOTS of them per report, SLOTS being KEY_SLOTS capped at 6.
//  The output register drains pending events while the next report waits;
//  in_tready rises in the cycle the final pending event moves out.
//  rst_n (synchronous) clears the stored report, pending events and out_tvalid.
//  out_tready low stalls the output register and, while events are pending behind it, the input.
//
`default_nettype none

`include "hid_keyboard_report_diff_defines.svh"

module hid_keyboard_report_diff #(
  parameter int KEY_SLOTS = 6
) (
  input  wire         clk,
  input  wire         rst_n,
  // input reports
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // new_key_0 [7:0] .. new_key_5 [47:40]
  // key events
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // event_key [7:0]
  output logic [0:0]  out_tuser,  // is_press [0]
  output logic        out_tlast   // last_event
);

  // slots beyond the report format are treated as absent
  localparam int SLOTS = (KEY_SLOTS > hkrd_pkg::MAX_SLOTS) ? hkrd_pkg::MAX_SLOTS
                                                           : KEY_SLOTS;
  localparam int LANES = 2 * SLOTS;

  hkrd_pkg::key_t [SLOTS-1:0] fresh;
  hkrd_pkg::key_t [SLOTS-1:0] prev_r;
  hkrd_pkg::key_t [LANES-1:0] lane_code;
  logic           [LANES-1:0] lane_hit;
  logic                       accept;
  hkrd_pkg::evt_t             evt;

  assign accept = in_tvalid && in_tready;

  // Lanes 0..SLOTS-1 look for presses (new slot missing from stored report),
  // lanes SLOTS..LANES-1 for releases (stored slot missing from new report).
  for (genvar i = 0; i < SLOTS; i++) begin : g_lane
    assign fresh[i]           = in_tdata[i*hkrd_pkg::KEY_W +: hkrd_pkg::KEY_W];
    assign lane_code[i]       = fresh[i];
    assign lane_code[SLOTS+i] = prev_r[i];

    hkrd_lane #(.SLOTS(SLOTS)) u_press (
      .code   (fresh[i]),
      .report (prev_r),
      .hit    (lane_hit[i])
    );

    hkrd_lane #(.SLOTS(SLOTS)) u_release (
      .code   (prev_r[i]),
      .report (fresh),
      .hit    (lane_hit[SLOTS+i])
    );
  end

  // stored report replaced on every accepted report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (accept) begin
      prev_r <= fresh;
    end
  end

  hkrd_merge #(.LANES(LANES)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (accept),
    .ld_mask   (lane_hit),
    .ld_codes  (lane_code),
    .ld_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_evt   (evt)
  );

  assign out_tdata = evt.key;
  assign out_tuser = evt.is_press;
  assign out_tlast = evt.last;

  // an empty slot never produces an event
  `HKRD_ASSERT_NOW(a_key_nonzero, out_tvalid, out_tdata != 8'd0)
  // events of one report go out without gaps
  `HKRD_ASSERT_NEXT(a_no_gap, out_tvalid && out_tready && !out_tlast, out_tvalid)
  // no new report is taken while more than the shown event is still pending
  `HKRD_ASSERT_NOW(a_hold_input, out_tvalid && !out_tready, !in_tready || out_tlast)

endmodule

`default_nettype wire

/* tb/tb_hid_keyboard_report_diff.sv */
// ----------------------------------------------------------------------------
// tb_hid_keyboard_report_diff
// Self-checking bench for the keyboard report differ.
// ----------------------------------------------------------------------------
// A queue of boot keyboard reports feeds a stream driver. On every accepted
// report the bench works out the press and release events from its own copy
// of the held report and queues them. A monitor checks each output
// transaction against the oldest queued event. A short directed set runs
// first, then random typing sequences in three pacing phases: slow sink,
// slow source and full rate. During full rate the sink stalls for a long
// stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hid_keyboard_report_diff;

  localparam int SLOTS            = hkrd_pkg::MAX_SLOTS;
  localparam int RANDOM_PER_PHASE = 130;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 40;
  localparam int RUN_LIMIT        = 2_000_000;

  // slot 0 in the lowest byte
  typedef hkrd_pkg::key_t [hkrd_pkg::MAX_SLOTS-1:0] report_t;

  typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // new_key_0 [7:0] .. new_key_5 [47:40]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // event_key [7:0]
  logic [0:0]  out_tuser;         // is_press [0]
  logic        out_tlast;         // last_event

  report_t        reports_to_send[$];
  hkrd_pkg::evt_t events_due[$];
  report_t        held_keys;      // bench copy of the stored report
  report_t        gen_prev;       // last report produced by the generator
  pace_t          pace          = PACE_SLOW_SINK;
  int             send_idle_pct = 10;
  int             recv_idle_pct = 68;
  int             hold_cycles;
  bit             hold_armed;
  int             error_count   = 0;

  hid_keyboard_report_diff #(.KEY_SLOTS(SLOTS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic report_t mk_report(hkrd_pkg::key_t k0, hkrd_pkg::key_t k1,
                                        hkrd_pkg::key_t k2, hkrd_pkg::key_t k3,
                                        hkrd_pkg::key_t k4, hkrd_pkg::key_t k5);
    report_t r;
    r[0] = k0; r[1] = k1; r[2] = k2; r[3] = k3; r[4] = k4; r[5] = k5;
    return r;
  endfunction

  function automatic bit holds_key(report_t r, hkrd_pkg::key_t code);
    for (int i = 0; i < SLOTS; i++)
      if (r[i] == code) return 1'b1;
    return 1'b0;
  endfunction

  // Presses in new-slot order, then releases in held-slot order; the final
  // event of the report carries last. Duplicates are reported per slot.
  function automatic void queue_key_events(report_t fresh);
    int first;
    first = events_due.size();
    for (int i = 0; i < SLOTS; i++)
      if (fresh[i] != '0 && !holds_key(held_keys, fresh[i]))
        events_due.push_back(hkrd_pkg::evt_t'{key: fresh[i], is_press: 1'b1,
                                              last: 1'b0});
    for (int i = 0; i < SLOTS; i++)
      if (held_keys[i] != '0 && !holds_key(fresh, held_keys[i]))
        events_due.push_back(hkrd_pkg::evt_t'{key: held_keys[i], is_press: 1'b0,
                                              last: 1'b0});
    if (events_due.size() > first) events_due[$].last = 1'b1;
    held_keys = fresh;
  endfunction

  // Mostly typing-like evolution of the previous report over a small code
  // pool (overlaps, duplicates), some reorders, some fully random reports.
  function automatic report_t next_report(report_t prev);
    report_t        r;
    int             mode;
    int             a;
    int             b;
    hkrd_pkg::key_t t;
    r    = prev;
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      for (int i = 0; i < SLOTS; i++)
        case ($urandom_range(0, 9))
          0, 1:    r[i] = '0;
          2, 3:    r[i] = hkrd_pkg::key_t'($urandom_range(4, 11));
          4:       r[i] = hkrd_pkg::key_t'($urandom);
          default: r[i] = prev[i];
        endcase
    end else if (mode < 85) begin
      a = $urandom_range(0, SLOTS - 1);
      b = $urandom_range(0, SLOTS - 1);
      t = r[a]; r[a] = r[b]; r[b] = t;
    end else begin
      for (int i = 0; i < SLOTS; i++)
        r[i] = ($urandom_range(0, 3) == 0) ? hkrd_pkg::key_t'(0)
                                           : hkrd_pkg::key_t'($urandom);
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Report driver: predicts on acceptance, then offers the next report.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      held_keys = '0;
    end else begin
      if (in_tvalid && in_tready) queue_key_events(report_t'(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (reports_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= reports_to_send.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long sink stall, once, at the start of the full-rate phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_armed  <= 1'b1;
    end else if (hold_armed && pace == PACE_FULL && in_tvalid) begin
      hold_cycles <= SINK_HOLD_CYCLES;
      hold_armed  <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Event monitor and sink pacing.
  always @(posedge clk) begin
    hkrd_pkg::evt_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (events_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected event key=%02h press=%0b last=%0b",
                                  out_tdata, out_tuser[0], out_tlast));
        end else begin
          want = events_due.pop_front();
          if (out_tdata !== want.key)
            flag_mismatch($sformatf("event_key %02h, want %02h", out_tdata, want.key));
          if (out_tuser[0] !== want.is_press)
            flag_mismatch($sformatf("is_press %0b, want %0b (key %02h)",
                                    out_tuser[0], want.is_press, want.key));
          if (out_tlast !== want.last)
            flag_mismatch($sformatf("last_event %0b, want %0b (key %02h)",
                                    out_tlast, want.last, want.key));
        end
      end
      if (hold_cycles != 0) out_tready <= 1'b0;
      else                  out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic wait_drained();
    while (reports_to_send.size() != 0 || in_tvalid || events_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(pace_t p, int s_pct, int r_pct);
    @(negedge clk);
    pace          = p;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      gen_prev = next_report(gen_prev);
      reports_to_send.push_back(gen_prev);
    end
    wait_drained();
  endtask

  initial begin
    // directed: no change, single press/release, extreme codes, duplicate
    // presses and releases, full swap of all slots, pure reorder
    reports_to_send.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    reports_to_send.push_back(mk_report(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    reports_to_send.push_back(mk_report(8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
    reports_to_send.push_back(mk_report(8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
    reports_to_send.push_back(mk_report(8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    reports_to_send.push_back(mk_report(8'h01, 8'hFF, 8'h80, 8'h7F, 8'hAA, 8'h55));
    reports_to_send.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    reports_to_send.push_back(mk_report(8'h2A, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00));
    reports_to_send.push_back(mk_report(8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A));
    reports_to_send.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    reports_to_send.push_back(mk_report(8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16));
    reports_to_send.push_back(mk_report(8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26));
    reports_to_send.push_back(mk_report(8'h26, 8'h25, 8'h24, 8'h23, 8'h22, 8'h21));
    reports_to_send.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80));
    reports_to_send.push_back(mk_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    reports_to_send.push_back(mk_report(8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'hFE));
    reports_to_send.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    gen_prev = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(PACE_SLOW_SINK,   10, 68);
    run_phase(PACE_SLOW_SOURCE, 68, 10);
    run_phase(PACE_FULL,         0,  0);

    if (error_count == 0) $display("DONE: 0 errors");
    else                  $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
